>>> design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character-to-sextet map for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int MaxRes = 4;
	localparam int CntW   = $clog2(MaxRes + 1);
	localparam int PtrW   = $clog2(MaxRes);

	localparam logic [7:0]  PadCode    = 8'h3D;
	localparam logic [7:0]  NulCode    = 8'h00;
	localparam logic [15:0] MaxResetVal = 16'd511;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_CAPACITY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_DECODE = 3'b001,
		PH_DONE   = 3'b010,
		PH_ERR    = 3'b100
	} phase_t;

	typedef struct packed {
		logic       bad;
		logic [5:0] val;
	} sext_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        is_status;
		status_t     status_code;
		logic [15:0] byte_total;
		logic        run_last;
	} res_t;

	typedef struct packed {
		logic [CntW-1:0]        cnt;
		res_t [MaxRes-1:0]      res;
	} batch_t;

	function automatic sext_t sextet(input logic [7:0] c);
		sext_t s;
		logic [7:0] d;
		s.bad = 1'b0;
		d     = 8'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			d = c - 8'h41;
		end else if (c inside {[8'h61:8'h7A]}) begin
			d = c - 8'h61 + 8'd26;
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			d = 8'd62;
		end else if (c == 8'h2F) begin
			d = 8'd63;
		end else begin
			s.bad = 1'b1;
		end
		s.val = d[5:0];
		return s;
	endfunction

endpackage

>>> design/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 text decoder, one character beat in, one byte or status beat out.
// ----------------------------------------------------------------------------
// Takes one character per cycle when not stalled. A character that completes
// a group of four yields up to three byte beats, and the end_of_text
// character adds a status beat, so one character can yield up to four output
// beats; the single output port drains them one per cycle while out_ready is
// high from a four-entry result register, and the input stalls until the
// last is taken. Zero-beat characters, and one-beat ones while out_ready is
// high, flow at one per cycle. On an error status, byte beats already sent
// for that string are to be discarded by the consumer. max_output_bytes
// (cfg_wdata, reset 511) may be written only while the block is idle.
module base64_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        is_status,
	output logic [1:0]  status_code,
	output logic [15:0] byte_total,
	output logic        run_last
);
	import b64d_pkg::*;

	logic   valid_s1;
	logic [7:0] char_s1;
	logic   eot_s1;
	logic   take;
	logic   load_ok;
	batch_t batch;
	res_t   out_res;

	b64d_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.take        (take),
		.valid_s1    (valid_s1),
		.char_s1     (char_s1),
		.eot_s1      (eot_s1)
	);

	b64d_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.char_s1   (char_s1),
		.eot_s1    (eot_s1),
		.load_ok   (load_ok),
		.take      (take),
		.batch     (batch)
	);

	b64d_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.batch     (batch),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign data_byte   = out_res.data_byte;
	assign is_status   = out_res.is_status;
	assign status_code = out_res.status_code;
	assign byte_total  = out_res.byte_total;
	assign run_last    = out_res.run_last;

	a_eot_gives_status: assert property (@(posedge clk) disable iff (!arst_n)
		take && eot_s1 |-> batch.cnt != '0)
		else $error("end of text beat produced no status");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status |-> run_last && data_byte == 8'd0)
		else $error("status beat not marked last or carries data");

	a_data_code_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_status |-> status_code == ST_OK && byte_total != 16'd0)
		else $error("byte beat with bad status code or zero total");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && batch.cnt != '0 |-> load_ok)
		else $error("batch loaded over undrained results");

endmodule

>>> design/b64d_in_reg.sv
// ----------------------------------------------------------------------------
// b64d_in_reg
// Input register: holds one character beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module b64d_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] char_s1,
	output logic       eot_s1
);
	import b64d_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
	end

endmodule

>>> design/b64d_core.sv
// ----------------------------------------------------------------------------
// b64d_core
// Group collection, sextet decode, capacity check and per-string state.
// Builds the full result batch for the held character in one pass.
// ----------------------------------------------------------------------------
module b64d_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            valid_s1,
	input  logic [7:0]      char_s1,
	input  logic            eot_s1,
	input  logic            load_ok,
	output logic            take,
	output b64d_pkg::batch_t batch
);
	import b64d_pkg::*;

	logic [15:0] max_q;
	logic [7:0]  grp_q [3];
	logic [1:0]  pos_q;
	phase_t      phase_q;
	status_t     err_q;
	logic [15:0] bytes_q;

	sext_t x0, x1, x2, x3;
	logic  p2, p3;
	logic  cap0, cap1, cap2;
	logic  do_grp, store, fin, err_set;
	status_t err_code, err_nxt;
	logic [1:0]  nd;
	logic [CntW-1:0] n;
	logic [7:0]  bytes_v [3];
	logic [15:0] b1, b2;

	assign x0 = sextet(grp_q[0]);
	assign x1 = sextet(grp_q[1]);
	assign x2 = sextet(grp_q[2]);
	assign x3 = sextet(char_s1);
	assign p2 = grp_q[2] == PadCode;
	assign p3 = char_s1 == PadCode;

	assign b1   = bytes_q + 16'd1;
	assign b2   = bytes_q + 16'd2;
	assign cap0 = bytes_q >= max_q;
	assign cap1 = b1 >= max_q;
	assign cap2 = b2 >= max_q;

	assign bytes_v[0] = {x0.val, x1.val[5:4]};
	assign bytes_v[1] = {x1.val[3:0], x2.val[5:2]};
	assign bytes_v[2] = {x2.val[1:0], x3.val};

	always_comb begin
		do_grp   = 1'b0;
		store    = 1'b0;
		fin      = 1'b0;
		err_set  = 1'b0;
		err_code = ST_OK;
		nd       = 2'd0;
		if (phase_q == PH_DECODE) begin
			if (char_s1 == NulCode) begin
				fin = 1'b1;
			end else if (pos_q == 2'd0 && p3) begin
				fin = 1'b1;
			end else if (pos_q != 2'd3) begin
				store = 1'b1;
			end else begin
				do_grp = 1'b1;
			end
		end
		if (do_grp) begin
			if (x0.bad || x1.bad) begin
				err_set = 1'b1; err_code = ST_BAD_CHAR;
			end else if (cap0) begin
				err_set = 1'b1; err_code = ST_CAPACITY;
			end else begin
				nd = 2'd1;
				if (p2) begin
					fin = 1'b1;
				end else if (x2.bad) begin
					err_set = 1'b1; err_code = ST_BAD_CHAR;
				end else if (cap1) begin
					err_set = 1'b1; err_code = ST_CAPACITY;
				end else begin
					nd = 2'd2;
					if (p3) begin
						fin = 1'b1;
					end else if (x3.bad) begin
						err_set = 1'b1; err_code = ST_BAD_CHAR;
					end else if (cap2) begin
						err_set = 1'b1; err_code = ST_CAPACITY;
					end else begin
						nd = 2'd3;
					end
				end
			end
		end
	end

	assign err_nxt = err_set ? err_code : err_q;
	assign n       = CntW'(nd) + CntW'(eot_s1);
	assign take    = valid_s1 && (load_ok || n == '0);

	always_comb begin
		batch.cnt = n;
		for (int k = 0; k < MaxRes; k++) begin
			batch.res[k] = '0;
			if (CntW'(k) < CntW'(nd)) begin
				batch.res[k].data_byte  = bytes_v[k % 3];
				batch.res[k].byte_total = bytes_q + 16'(k + 1);
			end else if (CntW'(k) == CntW'(nd)) begin
				batch.res[k].is_status   = 1'b1;
				batch.res[k].status_code = err_nxt;
				batch.res[k].byte_total  = bytes_q + 16'(nd);
			end
			batch.res[k].run_last = CntW'(k + 1) == n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MaxResetVal;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q[0] <= '0;
			grp_q[1] <= '0;
			grp_q[2] <= '0;
			pos_q    <= '0;
			phase_q  <= PH_DECODE;
			err_q    <= ST_OK;
			bytes_q  <= '0;
		end else if (take) begin
			if (eot_s1) begin
				grp_q[0] <= '0;
				grp_q[1] <= '0;
				grp_q[2] <= '0;
				pos_q    <= '0;
				phase_q  <= PH_DECODE;
				err_q    <= ST_OK;
				bytes_q  <= '0;
			end else begin
				if (store) begin
					grp_q[pos_q] <= char_s1;
					pos_q        <= pos_q + 2'd1;
				end
				if (do_grp) begin
					pos_q <= '0;
				end
				if (err_set) begin
					phase_q <= PH_ERR;
				end else if (fin) begin
					phase_q <= PH_DONE;
				end
				err_q   <= err_nxt;
				bytes_q <= bytes_q + 16'(nd);
			end
		end
	end

endmodule

>>> design/b64d_out_buf.sv
// ----------------------------------------------------------------------------
// b64d_out_buf
// Result register: holds one batch of up to four results and drains it
// one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module b64d_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  b64d_pkg::batch_t batch,
	output logic             load_ok,
	output logic             out_valid,
	input  logic             out_ready,
	output b64d_pkg::res_t   out_res
);
	import b64d_pkg::*;

	logic [CntW-1:0] cnt_q;
	logic [PtrW-1:0] rd_q;
	res_t            ent_q [MaxRes];
	logic            pop, load;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign load_ok   = cnt_q == '0 || (cnt_q == CntW'(1) && out_ready);
	assign load      = take && batch.cnt != '0;
	assign out_res   = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= batch.cnt;
			rd_q  <= '0;
		end else if (pop) begin
			cnt_q <= cnt_q - CntW'(1);
			rd_q  <= rd_q + PtrW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < MaxRes; k++) begin
				ent_q[k] <= batch.res[k];
			end
		end
	end

endmodule
